FILE: src/kwsub_pkg.sv
// Shared types and constants for the keyword substitution decoder.
`timescale 1ns / 1ps

package kwsub_pkg;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_MSG   = 2'd2;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] PLAIN_BASE   = 8'd97;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] plain_char;
    logic       found;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic apply;
    logic emit;
  } kwsub_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
  } kwsub_sts_t;

endpackage

FILE: src/keyword_substitution_decoder.sv
// Top level of the keyword substitution decoder.
// Each beat is handled in order: accept, compare the symbol against every
// filled key slot at once and register the hit vector, then update the table
// or emit the result. busy is high in the CMP and DONE states; a message beat
// shows its result on out_data with out_strobe for one cycle, in DONE after
// acceptance. The receiver cannot stall, so nothing is buffered. Clear, key and
// unused-kind beats give no result. The table needs no clearing pass after reset.
`timescale 1ns / 1ps

module keyword_substitution_decoder #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  kwsub_pkg::in_beat_t  in_data,
  output logic                 out_strobe,
  output kwsub_pkg::out_beat_t out_data
);

  kwsub_pkg::kwsub_cmd_t cmd;
  kwsub_pkg::kwsub_sts_t sts;

  kwsub_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  kwsub_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign out_strobe = cmd.emit;

endmodule

FILE: src/kwsub_datapath.sv
// Datapath: key table, fill count, parallel compare and result formatting.
`timescale 1ns / 1ps

module kwsub_datapath #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kwsub_pkg::in_beat_t   in_data,
  input  kwsub_pkg::kwsub_cmd_t cmd,
  output kwsub_pkg::kwsub_sts_t sts,
  output kwsub_pkg::out_beat_t  out_data
);

  localparam int IDX_W  = $clog2(ALPHABET_SIZE);
  localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);

  logic [1:0]               kind_r;
  logic [7:0]               symbol_r;
  logic [ALPHABET_SIZE-1:0] hit_r;
  logic [ALPHABET_SIZE-1:0] hit_nxt;
  logic [7:0]               table_r [ALPHABET_SIZE];
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_nxt;
  logic [IDX_W-1:0]         hit_idx;
  logic                     is_space;
  logic                     is_full;
  logic                     key_write;

  assign is_space = (symbol_r == kwsub_pkg::CHAR_SPACE);
  assign is_full  = (fill_r == FILL_W'(ALPHABET_SIZE));

  // compare against filled slots only
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      hit_nxt[i] = (FILL_W'(i) < fill_r) && (table_r[i] == symbol_r);
    end
  end

  // stored symbols are unique, so at most one bit of the hit vector is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (hit_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign key_write = cmd.apply && (kind_r == kwsub_pkg::KIND_KEY) && !is_space
                     && (symbol_r != kwsub_pkg::CHAR_NEWLINE) && !is_full && (hit_r == '0);

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.apply) begin
      unique case (kind_r)
        kwsub_pkg::KIND_CLEAR: fill_nxt = '0;
        kwsub_pkg::KIND_KEY:   fill_nxt = key_write ? fill_r + FILL_W'(1) : fill_r;
        default:               fill_nxt = fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_data.kind;
      symbol_r <= in_data.symbol;
    end
    if (cmd.cmp) begin
      hit_r <= hit_nxt;
    end
    if (key_write) begin
      table_r[fill_r[IDX_W-1:0]] <= symbol_r;
    end
  end

  always_comb begin
    if (is_space) begin
      out_data.plain_char = kwsub_pkg::CHAR_SPACE;
      out_data.found      = 1'b1;
    end else if (hit_r != '0) begin
      out_data.plain_char = kwsub_pkg::PLAIN_BASE + 8'(hit_idx);
      out_data.found      = 1'b1;
    end else begin
      out_data.plain_char = '0;
      out_data.found      = 1'b0;
    end
  end

  assign sts.kind = kind_r;

endmodule

FILE: src/kwsub_ctrl.sv
// Controller: sequences load, compare and apply for one beat.
`timescale 1ns / 1ps

module kwsub_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  kwsub_pkg::kwsub_sts_t sts,
  output kwsub_pkg::kwsub_cmd_t cmd,
  output logic                  busy
);

  kwsub_pkg::state_t state_r;
  kwsub_pkg::state_t state_nxt;

  always_comb begin
    unique case (state_r)
      kwsub_pkg::ST_IDLE: state_nxt = start ? kwsub_pkg::ST_CMP : kwsub_pkg::ST_IDLE;
      kwsub_pkg::ST_CMP:  state_nxt = kwsub_pkg::ST_DONE;
      kwsub_pkg::ST_DONE: state_nxt = kwsub_pkg::ST_IDLE;
      default:            state_nxt = kwsub_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      kwsub_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      kwsub_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      kwsub_pkg::ST_DONE: begin
        cmd.apply = 1'b1;
        cmd.emit  = (sts.kind == kwsub_pkg::KIND_MSG);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwsub_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/kwsub_checker.sv
// Port-level checker for the keyword substitution decoder, with its bind.
`timescale 1ns / 1ps

module kwsub_sva #(
  parameter int ALPHABET_SIZE = 26
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input kwsub_pkg::in_beat_t  in_data,
  input logic                 out_strobe,
  input kwsub_pkg::out_beat_t out_data
);

  a_strobe_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2) && $past(in_data.kind, 2) == kwsub_pkg::KIND_MSG)
    else $error("result without a message beat two cycles earlier");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.found |-> out_data.plain_char == 8'd0)
    else $error("unmatched result carries a nonzero character");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.found && out_data.plain_char != kwsub_pkg::CHAR_SPACE
    |-> out_data.plain_char >= kwsub_pkg::PLAIN_BASE
        && 32'(out_data.plain_char) < 32'(kwsub_pkg::PLAIN_BASE) + ALPHABET_SIZE)
    else $error("decoded letter outside the alphabet");

endmodule

bind keyword_substitution_decoder kwsub_sva #(
  .ALPHABET_SIZE (ALPHABET_SIZE)
) u_kwsub_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

FILE: test/kwsub_checker.sv
// Checker for the keyword substitution decoder: tracks the key table and compares decoded beats.
`timescale 1ns / 1ps

module kwsub_checker #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  kwsub_pkg::in_beat_t  in_data,
  input  logic                 out_strobe,
  input  kwsub_pkg::out_beat_t out_data,
  output int                   fail_count,
  output int                   outstanding
);
  import kwsub_pkg::*;

  logic [7:0] key_table [ALPHABET_SIZE];
  int         key_count;
  out_beat_t  pending_plain [$];
  out_beat_t  want;
  out_beat_t  decoded;
  int         errs;

  initial begin
    key_count   = 0;
    errs        = 0;
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int find_slot(input logic [7:0] sym);
    for (int n = 0; n < key_count && n < ALPHABET_SIZE; n++) begin
      if (key_table[n] == sym) return n;
    end
    return -1;
  endfunction

  function automatic bit decode_beat(input in_beat_t b, output out_beat_t res);
    int hit;
    res = '0;
    case (b.kind)
      KIND_CLEAR: begin
        key_count = 0;
        return 1'b0;
      end
      KIND_KEY: begin
        if (b.symbol == CHAR_SPACE || b.symbol == CHAR_NEWLINE) return 1'b0;
        if (key_count >= ALPHABET_SIZE) return 1'b0;
        if (find_slot(b.symbol) >= 0) return 1'b0;
        key_table[key_count] = b.symbol;
        key_count++;
        return 1'b0;
      end
      KIND_MSG: begin
        if (b.symbol == CHAR_SPACE) begin
          res.plain_char = CHAR_SPACE;
          res.found      = 1'b1;
          return 1'b1;
        end
        hit = find_slot(b.symbol);
        if (hit >= 0) begin
          res.plain_char = PLAIN_BASE + 8'(hit);
          res.found      = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_count = 0;
      pending_plain.delete();
      outstanding <= 0;
    end else begin
      if (out_strobe) begin
        if (pending_plain.size() == 0) begin
          errs++;
          $error("unexpected result beat: plain_char %0d, found %0d",
                 out_data.plain_char, out_data.found);
        end else begin
          want = pending_plain.pop_front();
          if (out_data.plain_char !== want.plain_char) begin
            errs++;
            $error("plain_char: expected %0d, got %0d", want.plain_char, out_data.plain_char);
          end
          if (out_data.found !== want.found) begin
            errs++;
            $error("found: expected %0d, got %0d", want.found, out_data.found);
          end
        end
      end
      if (start && !busy && decode_beat(in_data, decoded)) pending_plain.push_back(decoded);
      outstanding <= pending_plain.size();
      fail_count  <= errs;
    end
  end

endmodule

FILE: test/tb_keyword_substitution_decoder.sv
// Testbench top for the keyword substitution decoder: stimulus, reset, timeout and verdict.
`timescale 1ns / 1ps

module tb_keyword_substitution_decoder;
  import kwsub_pkg::*;

  localparam int         ALPHABET_SIZE = 26;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         BEAT_TARGET   = 750;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      start      = 1'b0;
  in_beat_t  in_data    = '0;
  logic      busy;
  logic      out_strobe;
  out_beat_t out_data;
  int        fail_count;
  int        outstanding;
  int        beats_sent = 0;
  bit        no_gaps    = 1'b0;

  always #1 clk = ~clk;

  keyword_substitution_decoder #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  kwsub_checker #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] symbol);
    in_data <= '{kind: kind, symbol: symbol};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic hold_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_spaced(input logic [1:0] kind, input logic [7:0] symbol);
    send_beat(kind, symbol);
    hold_gap();
  endtask

  task automatic drain(input int max_cycles);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic [7:0] pick_key_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return CHAR_SPACE;
    if (r == 1) return CHAR_NEWLINE;
    if (r < 5) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [7:0] key_pool [$];
    int         r;
    int         n;
    logic [7:0] sym;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_spaced(KIND_MSG, CHAR_SPACE);
    send_spaced(KIND_MSG, 8'h61);
    send_spaced(KIND_MSG, 8'h00);
    send_spaced(KIND_MSG, 8'hFF);
    send_spaced(KIND_KEY, CHAR_SPACE);
    send_spaced(KIND_KEY, CHAR_NEWLINE);
    send_spaced(KIND_KEY, 8'h00);
    send_spaced(KIND_KEY, 8'hFF);
    send_spaced(KIND_KEY, 8'h71);
    send_spaced(KIND_KEY, 8'h71);
    send_spaced(KIND_MSG, 8'h00);
    send_spaced(KIND_MSG, 8'hFF);
    send_spaced(KIND_MSG, 8'h71);
    send_spaced(KIND_MSG, CHAR_NEWLINE);
    send_spaced(KIND_MSG, CHAR_SPACE);
    send_spaced(KIND_UNUSED, 8'hFF);
    send_spaced(KIND_UNUSED, 8'h00);
    send_spaced(KIND_MSG, 8'h71);
    send_spaced(KIND_CLEAR, 8'hFF);
    send_spaced(KIND_MSG, 8'h71);
    send_spaced(KIND_KEY, 8'h7A);
    send_spaced(KIND_MSG, 8'h7A);
    send_spaced(KIND_MSG, 8'hFF);
    drain(100);

    while (beats_sent < BEAT_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        n = $urandom_range(5, 15);
        repeat (n) send_spaced(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          send_spaced(KIND_CLEAR, 8'($urandom_range(0, 255)));
          key_pool.delete();
        end
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(26, 40);
          repeat (n) begin
            sym = 8'($urandom_range(0, 255));
            key_pool.push_back(sym);
            send_spaced(KIND_KEY, sym);
          end
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            sym = pick_key_char();
            key_pool.push_back(sym);
            send_spaced(KIND_KEY, sym);
          end
        end
        n = $urandom_range(3, 15);
        repeat (n) begin
          r = $urandom_range(0, 19);
          if (r < 12 && key_pool.size() > 0) sym = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else if (r < 15) sym = CHAR_SPACE;
          else sym = 8'($urandom_range(0, 255));
          if (r == 19) send_spaced(KIND_UNUSED, sym);
          else send_spaced(KIND_MSG, sym);
        end
      end
      if ($urandom_range(0, 7) == 0) drain(100);
    end

    drain(100);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
